// File: rtl/pobb_pkg.sv
// Package for the point to oriented box squared distance core.
// Holds fixed-point widths, quaternion constants, payload types and the axis rounding helper.
// No dependencies.
package pobb_pkg;

    localparam int QUAT_W     = 16;
    localparam int QUAT_PARTS = 4;
    localparam int QUAT_ONE   = 16384;
    localparam int AXIS_FRAC  = 14;
    localparam int ROUND_HALF = 8192;
    localparam int AXSUM_W    = 2 * QUAT_W + 2;
    localparam int RES_W      = 64;
    localparam int USER_W     = 1;
    localparam int NUM_AXES   = 3;

    typedef logic signed [QUAT_W-1:0]   t_qpart;
    typedef logic signed [2*QUAT_W-1:0] t_qprod;
    typedef logic signed [AXSUM_W-1:0]  t_axsum;
    typedef logic [RES_W-1:0]           t_res;

    // round Q2.28 to Q1.14, half toward plus infinity, clamp to [-1, 1]
    function automatic t_qpart axis_round(input t_axsum t);
        t_axsum u;
        begin
            u = (t + t_axsum'(ROUND_HALF)) >>> AXIS_FRAC;
            if (u > t_axsum'(QUAT_ONE)) begin
                u = t_axsum'(QUAT_ONE);
            end else if (u < -t_axsum'(QUAT_ONE)) begin
                u = -t_axsum'(QUAT_ONE);
            end
            return QUAT_W'(u);
        end
    endfunction

endpackage

// File: rtl/point_obb_distance_squared_core.sv
// Top level of the point to oriented box squared distance core.
// Seven-stage streaming pipeline; depends on pobb_pkg.
//
// Takes one request per clock while the pipeline has room and returns the squared distance
// from a point to an oriented box as unsigned Q32.32, clamped to all ones with the saturation
// flag in tuser. Each request passes through the seven register stages (difference and
// quaternion products, axis rounding, projection multiply, projection sum, excess, square,
// accumulate), the last being the output register. A stalled output only holds the stages
// behind it that are full; bubbles keep collapsing, so the slave side keeps accepting until
// every stage holds a request.
module point_obb_distance_squared_core
    import pobb_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                                          i_clk,
    input  logic                                                          i_rst_n,
    input  logic                                                          s_axis_tvalid,
    output logic                                                          s_axis_tready,
    // point_x, point_y, point_z, center_x, center_y, center_z, orientation_quat,
    // extent_x, extent_y, extent_z, zero pad
    input  logic [((6*COORD_BITS+4*QUAT_W+3*(COORD_BITS-1)+7)/8)*8-1:0] s_axis_tdata,
    output logic                                                          m_axis_tvalid,
    input  logic                                                          m_axis_tready,
    // distance_squared
    output logic [RES_W-1:0]                                              m_axis_tdata,
    // saturated
    output logic [USER_W-1:0]                                             m_axis_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int EW   = CB - 1;
    localparam int PW   = DW + QUAT_W;
    localparam int RW   = PW - AXIS_FRAC;
    localparam int SW   = RW + 2;
    localparam int HW   = RES_W / 2;
    localparam int EXW  = (SW > HW + 1) ? SW : HW + 1;
    localparam int QOFF = 6 * CB;
    localparam int EOFF = QOFF + QUAT_PARTS * QUAT_W;
    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    // input slices
    logic signed [CB-1:0] w_pt [NUM_AXES];
    logic signed [CB-1:0] w_ct [NUM_AXES];
    t_qpart               w_q  [QUAT_PARTS];
    logic [EW-1:0]        w_ext [NUM_AXES];

    // stage 1
    logic signed [DW-1:0] n1_d [NUM_AXES];
    logic signed [DW-1:0] r1_d [NUM_AXES];
    logic [EW-1:0]        r1_ext [NUM_AXES];
    t_qprod r1_ww, r1_xx, r1_yy, r1_zz, r1_wx, r1_wy, r1_wz, r1_xy, r1_xz, r1_yz;

    // stage 2
    t_qpart               n2_ax [NUM_AXES][NUM_AXES];
    t_qpart               r2_ax [NUM_AXES][NUM_AXES];
    logic signed [DW-1:0] r2_d [NUM_AXES];
    logic [EW-1:0]        r2_ext [NUM_AXES];

    // stage 3
    logic signed [PW-1:0] r3_pr [NUM_AXES][NUM_AXES];
    logic [EW-1:0]        r3_ext [NUM_AXES];

    // stage 4
    logic signed [SW-1:0] n4_pj [NUM_AXES];
    logic signed [SW-1:0] r4_pj [NUM_AXES];
    logic [EW-1:0]        r4_ext [NUM_AXES];

    // stage 5
    logic [HW-1:0]        n5_e [NUM_AXES];
    logic [NUM_AXES-1:0]  n5_big;
    logic [HW-1:0]        r5_e [NUM_AXES];
    logic [NUM_AXES-1:0]  r5_big;

    // stage 6
    t_res                 r6_sq [NUM_AXES];
    logic [NUM_AXES-1:0]  r6_big;

    // stage 7
    t_res                 n7_dist;
    logic                 n7_sat;
    t_res                 r7_dist;
    logic                 r7_sat;

    // handshake: a stage advances when empty or when the stage after it advances
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = r7_dist;
    assign m_axis_tuser  = USER_W'(r7_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: coordinate differences and quaternion part products
    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            w_pt[j]  = s_axis_tdata[j*CB +: CB];
            w_ct[j]  = s_axis_tdata[(NUM_AXES+j)*CB +: CB];
            w_ext[j] = s_axis_tdata[EOFF + j*EW +: EW];
            n1_d[j]  = DW'(w_pt[j]) - DW'(w_ct[j]);
        end
        for (int k = 0; k < QUAT_PARTS; k++) begin
            w_q[k] = s_axis_tdata[QOFF + (QUAT_PARTS-1-k)*QUAT_W +: QUAT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_d   <= n1_d;
            r1_ext <= w_ext;
            r1_ww  <= w_q[0] * w_q[0];
            r1_xx  <= w_q[1] * w_q[1];
            r1_yy  <= w_q[2] * w_q[2];
            r1_zz  <= w_q[3] * w_q[3];
            r1_wx  <= w_q[0] * w_q[1];
            r1_wy  <= w_q[0] * w_q[2];
            r1_wz  <= w_q[0] * w_q[3];
            r1_xy  <= w_q[1] * w_q[2];
            r1_xz  <= w_q[1] * w_q[3];
            r1_yz  <= w_q[2] * w_q[3];
        end
    end

    // stage 2: rotated axes, rounded and clamped to Q1.14
    always_comb begin
        t_axsum ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
        ww = t_axsum'(r1_ww);
        xx = t_axsum'(r1_xx);
        yy = t_axsum'(r1_yy);
        zz = t_axsum'(r1_zz);
        wx = t_axsum'(r1_wx);
        wy = t_axsum'(r1_wy);
        wz = t_axsum'(r1_wz);
        xy = t_axsum'(r1_xy);
        xz = t_axsum'(r1_xz);
        yz = t_axsum'(r1_yz);
        n2_ax[0][0] = axis_round(ww + xx - yy - zz);
        n2_ax[0][1] = axis_round((xy + wz) <<< 1);
        n2_ax[0][2] = axis_round((xz - wy) <<< 1);
        n2_ax[1][0] = axis_round((xy - wz) <<< 1);
        n2_ax[1][1] = axis_round(ww - xx + yy - zz);
        n2_ax[1][2] = axis_round((yz + wx) <<< 1);
        n2_ax[2][0] = axis_round((xz + wy) <<< 1);
        n2_ax[2][1] = axis_round((yz - wx) <<< 1);
        n2_ax[2][2] = axis_round(ww - xx - yy + zz);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_ax  <= n2_ax;
            r2_d   <= r1_d;
            r2_ext <= r1_ext;
        end
    end

    // stage 3: projection products
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                for (int j = 0; j < NUM_AXES; j++) begin
                    r3_pr[i][j] <= PW'(r2_d[j]) * PW'(r2_ax[i][j]);
                end
            end
            r3_ext <= r2_ext;
        end
    end

    // stage 4: round each term to Q16.16 and sum
    always_comb begin
        logic signed [PW-1:0] t;
        logic signed [SW-1:0] acc;
        for (int i = 0; i < NUM_AXES; i++) begin
            acc = '0;
            for (int j = 0; j < NUM_AXES; j++) begin
                t   = (r3_pr[i][j] + PW'(ROUND_HALF)) >>> AXIS_FRAC;
                acc = acc + SW'(RW'(t));
            end
            n4_pj[i] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_pj  <= n4_pj;
            r4_ext <= r3_ext;
        end
    end

    // stage 5: excess of the absolute projection over the half-extent
    always_comb begin
        logic [SW-1:0]  mag;
        logic [SW-1:0]  ext;
        logic [EXW-1:0] e;
        for (int i = 0; i < NUM_AXES; i++) begin
            mag = r4_pj[i][SW-1] ? SW'(-r4_pj[i]) : SW'(r4_pj[i]);
            ext = SW'(r4_ext[i]);
            e   = (mag > ext) ? EXW'(mag - ext) : '0;
            n5_e[i]   = e[HW-1:0];
            n5_big[i] = (e[EXW-1:HW] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_e   <= n5_e;
            r5_big <= n5_big;
        end
    end

    // stage 6: square the excess
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r6_sq[i] <= RES_W'(r5_e[i]) * RES_W'(r5_e[i]);
            end
            r6_big <= r5_big;
        end
    end

    // stage 7: accumulate with saturation
    always_comb begin
        logic [RES_W+1:0] sum;
        sum = (RES_W+2)'(r6_sq[0]) + (RES_W+2)'(r6_sq[1]) + (RES_W+2)'(r6_sq[2]);
        n7_sat  = (|r6_big) || (sum[RES_W+1:RES_W] != '0);
        n7_dist = n7_sat ? '1 : sum[RES_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r7_dist <= n7_dist;
            r7_sat  <= n7_sat;
        end
    end

    a_sat_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (&m_axis_tdata))
        else $error("saturated result is not all ones");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input blocked while a pipeline stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

endmodule
